FILE: rtl/indexed_min_heap_defines.svh
// Assertion macros for the indexed min-heap.
`ifndef INDEXED_MIN_HEAP_DEFINES_SVH
`define INDEXED_MIN_HEAP_DEFINES_SVH

`ifndef SYNTHESIS
`define IMH_ASSERT_IMPL(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("implication check failed");
`define IMH_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("next-cycle check failed");
`else
`define IMH_ASSERT_IMPL(lbl, clk, rstn, pre, post)
`define IMH_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif

`endif

FILE: rtl/imh_pkg.sv
package imh_pkg;

  localparam int unsigned KEY_W   = 31;
  localparam int unsigned ID_W    = 10;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned ID_SPACE = 1 << ID_W;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_POP    = 2'd1,
    KIND_DEC    = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_FULL     = 3'd1,
    STAT_EMPTY    = 3'd2,
    STAT_ABSENT   = 3'd3,
    STAT_PRESENT  = 3'd4,
    STAT_NOT_LOW  = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_LOOK,
    ST_STORED,
    ST_DEC_CMP,
    ST_POP_LAST,
    ST_UP_CHK,
    ST_UP_CMP,
    ST_DN_CHK,
    ST_DN_L,
    ST_DN_R,
    ST_DN_DEC,
    ST_PLACE,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;
  } entry_t;

endpackage

FILE: rtl/indexed_min_heap.sv
// Indexed binary min-heap, one request at a time, result in an output register.
// Insert: the new entry climbs one level per parent compare; decrease-key first compares
//   with the stored key. Pop: the last entry moves to the root and descends.
// The next beat is taken in the cycle after the result is loaded; pops are bound
// by the single read port of the slot memory.
// Reset (async, active low) empties the heap; the id-map clear (ST_CLR) holds s_axis_tready low.
`include "indexed_min_heap_defines.svh"

module indexed_min_heap
  import imh_pkg::*;
#(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [30:0] key, [40:31] item_id, rest zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [9:0] out_id, [40:10] out_key, [51:41] count, rest zero
  output logic [2:0]  m_axis_tuser    // [2:0] status
);

  // slots 1..CAPACITY hold entries; slot index and fill count share one width
  localparam int unsigned SLOT_W = $clog2(CAPACITY + 1);
  localparam int unsigned DEPTH  = CAPACITY + 1;

  // ---------------- memories ----------------
  entry_t            heap_mem [DEPTH];
  logic [SLOT_W-1:0] pos_mem  [ID_SPACE];

  logic              heap_we;
  logic [SLOT_W-1:0] heap_waddr, heap_raddr;
  entry_t            heap_wdata, heap_rdata_q;
  logic              pos_we;
  logic [ID_W-1:0]   pos_waddr, pos_raddr;
  logic [SLOT_W-1:0] pos_wdata, pos_rdata_q;

  always_ff @(posedge clk_i) begin
    if (heap_we) begin
      heap_mem[heap_waddr] <= heap_wdata;
    end
    heap_rdata_q <= heap_mem[heap_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (pos_we) begin
      pos_mem[pos_waddr] <= pos_wdata;
    end
    pos_rdata_q <= pos_mem[pos_raddr];
  end

  // ---------------- control state ----------------
  state_e            state_q, state_d;
  logic [ID_W-1:0]   clr_q, clr_d;
  logic [SLOT_W-1:0] count_q, count_d;
  logic [SLOT_W-1:0] s_q, s_d;            // current hole slot
  logic [SLOT_W-1:0] best_slot_q, best_slot_d;
  entry_t            cur_q, cur_d;        // entry being sifted
  entry_t            best_q, best_d;      // smaller child
  kind_e             kind_q, kind_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [ID_W-1:0]   id_q, id_d;
  status_e           res_status_q, res_status_d;
  logic [ID_W-1:0]   res_id_q, res_id_d;
  logic [KEY_W-1:0]  res_key_q, res_key_d;

  // output register
  logic              m_valid_q, m_valid_d;
  status_e           m_status_q, m_status_d;
  logic [ID_W-1:0]   m_id_q, m_id_d;
  logic [KEY_W-1:0]  m_key_q, m_key_d;
  logic [COUNT_W-1:0] m_count_q, m_count_d;

  logic [SLOT_W:0]   left_w, right_w, count_w;
  logic              in_beat;

  assign left_w  = {s_q, 1'b0};
  assign right_w = {s_q, 1'b1};
  assign count_w = {1'b0, count_q};
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_beat = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    count_d      = count_q;
    s_d          = s_q;
    best_slot_d  = best_slot_q;
    cur_d        = cur_q;
    best_d       = best_q;
    kind_d       = kind_q;
    key_d        = key_q;
    id_d         = id_q;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    res_key_d    = res_key_q;
    m_valid_d    = m_valid_q && !m_axis_tready;
    m_status_d   = m_status_q;
    m_id_d       = m_id_q;
    m_key_d      = m_key_q;
    m_count_d    = m_count_q;

    heap_we    = 1'b0;
    heap_waddr = s_q;
    heap_wdata = cur_q;
    heap_raddr = SLOT_W'(1);
    pos_we     = 1'b0;
    pos_waddr  = cur_q.id;
    pos_wdata  = s_q;
    pos_raddr  = s_axis_tdata[40:31];

    unique case (state_q)
      ST_CLR: begin
        pos_we    = 1'b1;
        pos_waddr = clr_q;
        pos_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == {ID_W{1'b1}}) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        // root read and id lookup issued together
        if (in_beat) begin
          kind_d  = kind_e'(s_axis_tuser);
          key_d   = s_axis_tdata[30:0];
          id_d    = s_axis_tdata[40:31];
          state_d = ST_LOOK;
        end
      end

      ST_LOOK: begin
        res_status_d = STAT_OK;
        res_id_d     = id_q;
        res_key_d    = '0;
        heap_raddr   = pos_rdata_q;
        unique case (kind_q)
          KIND_INSERT: begin
            if (pos_rdata_q != '0) begin
              res_status_d = STAT_PRESENT;
              state_d      = ST_STORED;
            end else if (count_q == SLOT_W'(CAPACITY)) begin
              res_status_d = STAT_FULL;
              state_d      = ST_FIN;
            end else begin
              count_d   = count_q + 1'b1;
              s_d       = count_q + 1'b1;
              cur_d     = '{id: id_q, key: key_q};
              res_key_d = key_q;
              state_d   = ST_UP_CHK;
            end
          end
          KIND_DEC: begin
            if (pos_rdata_q == '0 || pos_rdata_q > count_q) begin
              res_status_d = STAT_ABSENT;
              state_d      = ST_FIN;
            end else begin
              s_d     = pos_rdata_q;
              state_d = ST_DEC_CMP;
            end
          end
          KIND_POP: begin
            if (count_q == '0) begin
              res_status_d = STAT_EMPTY;
              res_id_d     = '0;
              state_d      = ST_FIN;
            end else begin
              // heap_rdata_q is the root here; fetch the last entry next
              heap_raddr = count_q;
              res_id_d   = heap_rdata_q.id;
              res_key_d  = heap_rdata_q.key;
              state_d    = ST_POP_LAST;
            end
          end
          default: begin
            res_id_d = '0;
            state_d  = ST_FIN;
          end
        endcase
      end

      ST_STORED: begin
        res_key_d = heap_rdata_q.key;
        state_d   = ST_FIN;
      end

      ST_DEC_CMP: begin
        if (key_q >= heap_rdata_q.key) begin
          res_status_d = STAT_NOT_LOW;
          res_key_d    = heap_rdata_q.key;
          state_d      = ST_FIN;
        end else begin
          cur_d     = '{id: id_q, key: key_q};
          res_key_d = key_q;
          state_d   = ST_UP_CHK;
        end
      end

      ST_POP_LAST: begin
        pos_we    = 1'b1;
        pos_waddr = res_id_q;
        pos_wdata = '0;
        count_d   = count_q - 1'b1;
        if (count_q == SLOT_W'(1)) begin
          state_d = ST_FIN;
        end else begin
          cur_d   = heap_rdata_q;
          s_d     = SLOT_W'(1);
          state_d = ST_DN_CHK;
        end
      end

      ST_UP_CHK: begin
        heap_raddr = s_q >> 1;
        if (s_q == SLOT_W'(1)) begin
          state_d = ST_PLACE;
        end else begin
          state_d = ST_UP_CMP;
        end
      end

      ST_UP_CMP: begin
        if (cur_q.key < heap_rdata_q.key) begin
          // parent drops into the hole
          heap_we    = 1'b1;
          heap_wdata = heap_rdata_q;
          pos_we     = 1'b1;
          pos_waddr  = heap_rdata_q.id;
          s_d        = s_q >> 1;
          state_d    = ST_UP_CHK;
        end else begin
          state_d = ST_PLACE;
        end
      end

      ST_DN_CHK: begin
        heap_raddr = left_w[SLOT_W-1:0];
        if (left_w > count_w) begin
          state_d = ST_PLACE;
        end else begin
          state_d = ST_DN_L;
        end
      end

      ST_DN_L: begin
        best_d      = heap_rdata_q;
        best_slot_d = left_w[SLOT_W-1:0];
        heap_raddr  = right_w[SLOT_W-1:0];
        if (right_w <= count_w) begin
          state_d = ST_DN_R;
        end else begin
          state_d = ST_DN_DEC;
        end
      end

      ST_DN_R: begin
        // left wins ties
        if (heap_rdata_q.key < best_q.key) begin
          best_d      = heap_rdata_q;
          best_slot_d = right_w[SLOT_W-1:0];
        end
        state_d = ST_DN_DEC;
      end

      ST_DN_DEC: begin
        if (best_q.key < cur_q.key) begin
          heap_we    = 1'b1;
          heap_wdata = best_q;
          pos_we     = 1'b1;
          pos_waddr  = best_q.id;
          s_d        = best_slot_q;
          state_d    = ST_DN_CHK;
        end else begin
          state_d = ST_PLACE;
        end
      end

      ST_PLACE: begin
        heap_we = 1'b1;
        pos_we  = 1'b1;
        state_d = ST_FIN;
      end

      ST_FIN: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d  = 1'b1;
          m_status_d = res_status_q;
          m_id_d     = res_id_q;
          m_key_d    = res_key_q;
          m_count_d  = COUNT_W'(count_q);
          state_d    = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLR;
      clr_q     <= '0;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q          <= s_d;
    best_slot_q  <= best_slot_d;
    cur_q        <= cur_d;
    best_q       <= best_d;
    kind_q       <= kind_d;
    key_q        <= key_d;
    id_q         <= id_d;
    res_status_q <= res_status_d;
    res_id_q     <= res_id_d;
    res_key_q    <= res_key_d;
    m_status_q   <= m_status_d;
    m_id_q       <= m_id_d;
    m_key_q      <= m_key_d;
    m_count_q    <= m_count_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tdata  = {4'd0, m_count_q, m_key_q, m_id_q};

  // ---------------- checks ----------------
  `IMH_ASSERT_IMPL(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= SLOT_W'(CAPACITY))
  `IMH_ASSERT_NEXT(a_busy_after_beat, clk_i, rst_ni, in_beat, !s_axis_tready)
  `IMH_ASSERT_IMPL(a_hole_nonzero, clk_i, rst_ni,
    state_q == ST_UP_CHK || state_q == ST_UP_CMP || state_q == ST_PLACE, s_q != '0)
  `IMH_ASSERT_IMPL(a_empty_means_zero, clk_i, rst_ni,
    state_q == ST_FIN && res_status_q == STAT_EMPTY, count_q == '0)

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps

module tb;
  import imh_pkg::*;

  localparam int unsigned CAP = 1024;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;   // [30:0] key, [40:31] item_id
  logic [1:0]  s_axis_tuser;   // [1:0] kind
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;   // [9:0] out_id, [40:10] out_key, [51:41] count
  logic [2:0]  m_axis_tuser;   // [2:0] status

  indexed_min_heap #(.CAPACITY(CAP)) u_dut (.*);

  typedef struct packed {
    status_e            status;
    logic [ID_W-1:0]    id;
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] count;
  } reply_t;

  typedef struct {
    kind_e            kind;
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  id;
    bit               fixed;   // reply typed in below, else predicted
    reply_t           reply;
  } row_t;

  // Shadow heap: slots 1..heap_size, id -> slot map (0 = absent)
  logic [KEY_W-1:0] heap_key [1:CAP];
  logic [ID_W-1:0]  heap_id  [1:CAP];
  int unsigned      slot_of  [ID_SPACE];
  int unsigned      heap_size;

  reply_t replies_due[$];
  int     errors;
  int     send_idle_pct;
  int     recv_stall_pct;

  function automatic void swap_slots(int unsigned a, int unsigned b);
    logic [KEY_W-1:0] k;
    logic [ID_W-1:0]  i;
    k = heap_key[a]; i = heap_id[a];
    heap_key[a] = heap_key[b]; heap_id[a] = heap_id[b];
    heap_key[b] = k; heap_id[b] = i;
    slot_of[heap_id[a]] = a;
    slot_of[heap_id[b]] = b;
  endfunction

  function automatic void climb(int unsigned s);
    while (s > 1 && heap_key[s] < heap_key[s / 2]) begin
      swap_slots(s, s / 2);
      s = s / 2;
    end
  endfunction

  function automatic void descend(int unsigned s);
    int unsigned l, b;
    forever begin
      l = 2 * s;
      if (l > heap_size) break;
      b = l;
      if (l + 1 <= heap_size && heap_key[l + 1] < heap_key[l]) b = l + 1;
      if (heap_key[b] < heap_key[s]) begin
        swap_slots(s, b);
        s = b;
      end else break;
    end
  endfunction

  function automatic reply_t heap_apply(kind_e kind, logic [KEY_W-1:0] key,
                                        logic [ID_W-1:0] id);
    reply_t r;
    int unsigned s;
    r = '{STAT_OK, '0, '0, '0};
    case (kind)
      KIND_INSERT: begin
        r.id = id;
        if (slot_of[id] != 0) begin
          r.status = STAT_PRESENT;
          r.key = heap_key[slot_of[id]];
        end else if (heap_size >= CAP) begin
          r.status = STAT_FULL;
        end else begin
          heap_size++;
          heap_key[heap_size] = key;
          heap_id[heap_size] = id;
          slot_of[id] = heap_size;
          climb(heap_size);
          r.key = key;
        end
      end
      KIND_POP: begin
        if (heap_size == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.id = heap_id[1];
          r.key = heap_key[1];
          slot_of[heap_id[1]] = 0;
          s = heap_size;
          heap_size--;
          if (s > 1) begin
            heap_key[1] = heap_key[s];
            heap_id[1] = heap_id[s];
            slot_of[heap_id[1]] = 1;
            descend(1);
          end
        end
      end
      KIND_DEC: begin
        r.id = id;
        s = slot_of[id];
        if (s == 0) begin
          r.status = STAT_ABSENT;
        end else if (key >= heap_key[s]) begin
          r.status = STAT_NOT_LOW;
          r.key = heap_key[s];
        end else begin
          heap_key[s] = key;
          climb(s);
          r.key = key;
        end
      end
      default: ;
    endcase
    r.count = heap_size[COUNT_W-1:0];
    return r;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("** indexed_min_heap: FAILED **");
    $finish;
  end

  // Result side: random stall, compare each beat with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (replies_due.size() == 0) begin
        $error("unexpected result beat");
        errors++;
      end else begin
        reply_t e;
        e = replies_due.pop_front();
        if (m_axis_tuser !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, m_axis_tuser); errors++;
        end
        if (m_axis_tdata[9:0] !== e.id) begin
          $error("out_id: expected %0d, got %0d", e.id, m_axis_tdata[9:0]); errors++;
        end
        if (m_axis_tdata[40:10] !== e.key) begin
          $error("out_key: expected %0d, got %0d", e.key, m_axis_tdata[40:10]); errors++;
        end
        if (m_axis_tdata[51:41] !== e.count) begin
          $error("count: expected %0d, got %0d", e.count, m_axis_tdata[51:41]); errors++;
        end
        if (m_axis_tdata[55:52] !== 4'd0) begin
          $error("pad: expected 0, got %0h", m_axis_tdata[55:52]); errors++;
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // One request beat; idles before it, waits for acceptance, records expectation
  task automatic send_request(kind_e kind, logic [KEY_W-1:0] key, logic [ID_W-1:0] id,
                              bit fixed, reply_t typed);
    reply_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {7'd0, id, key};
    do @(posedge clk_i); while (!s_axis_tready);
    p = heap_apply(kind, key, id);
    if (fixed && p !== typed) begin
      $error("typed reply disagrees with shadow heap: expected %p, got %p", typed, p);
      errors++;
    end
    replies_due.push_back(p);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk_i);
  endtask

  localparam logic [KEY_W-1:0] KMAX = '1;
  localparam logic [ID_W-1:0]  IMAX = '1;

  // Pick an id that is likely present (well-formed decrease) or random
  function automatic logic [ID_W-1:0] pick_id(int unsigned span);
    if (heap_size != 0 && $urandom_range(3) != 0)
      return heap_id[$urandom_range(heap_size, 1)];
    return ID_W'($urandom_range(span));
  endfunction

  initial begin
    row_t rows[$];
    kind_e kd;
    logic [KEY_W-1:0] ky;
    logic [ID_W-1:0]  ix;
    int unsigned n, pick, span;

    errors = 0;
    heap_size = 0;
    foreach (slot_of[i]) slot_of[i] = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = KIND_INSERT;
    m_axis_tready = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty pop, extremes, duplicate, absent, not lower, unused kind
    rows = '{
      '{KIND_POP,    '0,   '0,   1, '{STAT_EMPTY,  '0,   '0,   11'd0}},
      '{KIND_DEC,    '0,   IMAX, 1, '{STAT_ABSENT, IMAX, '0,   11'd0}},
      '{KIND_INSERT, KMAX, IMAX, 1, '{STAT_OK,     IMAX, KMAX, 11'd1}},
      '{KIND_INSERT, '0,   IMAX, 1, '{STAT_PRESENT, IMAX, KMAX, 11'd1}},
      '{KIND_INSERT, '0,   '0,   1, '{STAT_OK,     '0,   '0,   11'd2}},
      '{KIND_DEC,    '0,   '0,   1, '{STAT_NOT_LOW, '0,  '0,   11'd2}},
      '{KIND_NONE,   KMAX, IMAX, 1, '{STAT_OK,     '0,   '0,   11'd2}},
      '{KIND_INSERT, 31'd500, 10'd5, 0, '{STAT_OK, '0, '0, '0}},
      '{KIND_INSERT, 31'd500, 10'd6, 0, '{STAT_OK, '0, '0, '0}},
      '{KIND_INSERT, 31'd300, 10'd7, 0, '{STAT_OK, '0, '0, '0}},
      '{KIND_DEC,    31'd1,   IMAX,  0, '{STAT_OK, '0, '0, '0}},
      '{KIND_DEC,    31'd1,   10'd6, 0, '{STAT_OK, '0, '0, '0}},
      '{KIND_DEC,    31'd1,   10'd7, 0, '{STAT_OK, '0, '0, '0}},
      '{KIND_POP,    '0, '0, 0, '{STAT_OK, '0, '0, '0}},
      '{KIND_POP,    '0, '0, 0, '{STAT_OK, '0, '0, '0}},
      '{KIND_POP,    '0, '0, 0, '{STAT_OK, '0, '0, '0}},
      '{KIND_POP,    '0, '0, 0, '{STAT_OK, '0, '0, '0}},
      '{KIND_POP,    '0, '0, 0, '{STAT_OK, '0, '0, '0}},
      '{KIND_POP,    '0, '0, 0, '{STAT_OK, '0, '0, '0}}
    };
    foreach (rows[i])
      send_request(rows[i].kind, rows[i].key, rows[i].id, rows[i].fixed, rows[i].reply);

    // Fill to capacity, insert again when full (every id is held, so the
    // duplicate answer wins), then pop it down to 800 entries (ties on small keys)
    for (int i = 0; i < CAP; i++)
      send_request(KIND_INSERT, KEY_W'($urandom_range(40)), i[ID_W-1:0], 0, '0);
    send_request(KIND_INSERT, 31'd3, IMAX, 0, '0);
    drain();  // hold off until every reply is in
    rows.delete();
    ix = ID_W'(CAP - 1);
    send_request(KIND_DEC, 31'd0, ix, 0, '0);
    while (heap_size > 800) send_request(KIND_POP, '0, '0, 0, '0);

    // Random phases: free run, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 84 : (ph == 3) ? 25 : 0;
      recv_stall_pct = (ph == 2) ? 84 : (ph == 3) ? 25 : 0;
      n = (ph == 0) ? 300 : 150;
      span = (ph % 2) ? 63 : 1023;  // small id space gives duplicates
      for (int i = 0; i < n; i++) begin
        pick = $urandom_range(99);
        ky = KEY_W'($urandom());
        if ($urandom_range(3) == 0) ky = ky & 31'h3F;
        if (pick < 40) begin
          kd = KIND_INSERT; ix = ID_W'($urandom_range(span));
        end else if (pick < 75) begin
          kd = KIND_POP; ix = ID_W'($urandom());
        end else if (pick < 97) begin
          kd = KIND_DEC; ix = pick_id(span);
          if (slot_of[ix] != 0 && $urandom_range(4) != 0)
            ky = KEY_W'(heap_key[slot_of[ix]] -
                        $urandom_range(heap_key[slot_of[ix]] > 0 ? 9 : 0));
        end else begin
          kd = KIND_NONE; ix = ID_W'($urandom());
        end
        send_request(kd, ky, ix, 0, '0);
      end
    end

    drain();
    repeat (200) @(posedge clk_i);
    if (errors == 0 && replies_due.size() == 0) begin
      $display("** indexed_min_heap: PASSED **");
    end else begin
      $display("** indexed_min_heap: FAILED **");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/imh_pkg.sv
rtl/indexed_min_heap.sv
bench/tb.sv
